// ===== hw/rtl/lnv_pkg.sv =====
package lnv_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LenW = 7;

  localparam logic [CfgIdxW-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_EPSILON = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_ENABLE = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] gain;
    logic signed [15:0] offset;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] norm_value;
    logic last_of_vector;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CUBE1,
    ST_CUBE2,
    ST_P1_RD,
    ST_P1_D,
    ST_P1_SQ,
    ST_P1_ACC,
    ST_DIV_VAR,
    ST_DIV_INV,
    ST_SQRT,
    ST_P2_RD,
    ST_P2_D,
    ST_P2_MUL1,
    ST_P2_MUL2,
    ST_DIV_Y,
    ST_P2_OUT
  } state_e;

endpackage

// ===== hw/rtl/lnv_ram.sv =====
module lnv_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/layer_norm_vector_unit.sv =====
// layer normalization of one vector, fixed point
// input channel: one beat per element (sample q8.8, gain q4.12, offset q8.8),
//   accepted when in_valid_i is high and in_stall_o is low
// output channel: one beat per element (norm_value q8.8 saturated,
//   last_of_vector on the final one), in load order
// configuration: plain write port, index 0 vector_length, 1 epsilon,
//   2 offset_enable; write only while idle
// loading takes one cycle per beat; after the closing beat the block stalls
//   its input while it computes: m cubed, the variance pass over the elements,
//   the shared restoring divider (variance, then 2^48 / s), the digit-pair
//   square root, then per element the rounding divide by m in the divider
//   and one output step
// the shared one-bit-per-cycle divider sets the per-element output time
// a finished beat sits in the output register; while the receiver stalls
//   the sequencer holds at its output step, and after the last beat the block
//   takes new input even while that beat still waits
// reset empties the output register, zeroes load count and running sum and
//   restores vector_length 64, epsilon 1, offsets enabled
module layer_norm_vector_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lnv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lnv_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lnv_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lnv_pkg::out_beat_t            out_data_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // configuration
  logic [lnv_pkg::LenW-1:0] vlen_q;
  logic [15:0]              eps_q;
  logic                     off_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q   <= 7'd64;
      eps_q    <= 16'd1;
      off_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lnv_pkg::REG_VECTOR_LENGTH: vlen_q   <= cfg_data_i[lnv_pkg::LenW-1:0];
        lnv_pkg::REG_EPSILON:       eps_q    <= cfg_data_i;
        lnv_pkg::REG_OFFSET_ENABLE: off_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // length 0 acts as 1, above the store depth acts as the depth
  logic [lnv_pkg::LenW-1:0] eff_len;
  always_comb begin
    if (vlen_q == '0) begin
      eff_len = 7'd1;
    end else if (32'(vlen_q) > MAX_LEN) begin
      eff_len = lnv_pkg::LenW'(MAX_LEN);
    end else begin
      eff_len = vlen_q;
    end
  end

  lnv_pkg::state_e state_q, state_d;

  logic [lnv_pkg::LenW-1:0] cnt_q, cnt_d;     // elements loaded
  logic signed [23:0]       sum_q, sum_d;     // running sample sum
  logic [lnv_pkg::LenW-1:0] m_q, m_d;         // elements in this vector
  logic [lnv_pkg::LenW-1:0] idx_q, idx_d;     // pass element index
  logic [13:0]              mm_q, mm_d;
  logic [18:0]              m3_q, m3_d;
  logic signed [23:0]       dv_q, dv_d;       // m * x - sum
  logic [45:0]              sq_q, sq_d;
  logic [51:0]              ssq_q, ssq_d;
  logic signed [15:0]       g_q, g_d;
  logic signed [15:0]       ofs_q, ofs_d;
  logic [47:0]              p1_q, p1_d;
  logic [24:0]              inv_q, inv_d;
  logic signed [15:0]       y_q, y_d;

  // shared restoring divider
  logic [63:0] div_num_q, div_num_d;
  logic [31:0] div_rem_q, div_rem_d;
  logic [31:0] div_den_q, div_den_d;
  logic [5:0]  div_cnt_q, div_cnt_d;

  // square root
  logic [48:0] sq_a_q, sq_a_d;
  logic [48:0] sq_r_q, sq_r_d;
  logic [4:0]  sq_cnt_q, sq_cnt_d;

  // output register
  logic      out_valid_q, out_valid_d;
  lnv_pkg::out_beat_t out_q, out_d;

  // store: sample, gain, offset side by side
  logic          ram_we;
  logic [47:0]   ram_rdata;
  logic [AW-1:0] ram_raddr;

  assign ram_we    = (state_q == lnv_pkg::ST_LOAD) && in_valid_i;
  assign ram_raddr = idx_q[AW-1:0];

  lnv_ram #(
    .Width(48),
    .Depth(MAX_LEN)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({in_data_i.sample, in_data_i.gain, in_data_i.offset}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic signed [15:0] rd_sample, rd_gain, rd_offset;
  assign rd_sample = ram_rdata[47:32];
  assign rd_gain   = ram_rdata[31:16];
  assign rd_offset = ram_rdata[15:0];

  // divider step
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [63:0] div_num_nx;
  logic [31:0] div_rem_nx;
  logic        div_last;
  always_comb begin
    rem_sh     = {div_rem_q, div_num_q[63]};
    div_ge     = rem_sh >= {1'b0, div_den_q};
    div_rem_nx = div_ge ? 32'(rem_sh - {1'b0, div_den_q}) : rem_sh[31:0];
    div_num_nx = {div_num_q[62:0], div_ge};
    div_last   = (div_cnt_q == 6'd63);
  end

  // square root step
  logic [48:0] sq_bit, sq_t;
  logic [48:0] sq_a_nx, sq_r_nx;
  always_comb begin
    sq_bit = 49'd1 << {sq_cnt_q, 1'b0};
    sq_t   = sq_r_q + sq_bit;
    if (sq_a_q >= sq_t) begin
      sq_a_nx = sq_a_q - sq_t;
      sq_r_nx = (sq_r_q >> 1) + sq_bit;
    end else begin
      sq_a_nx = sq_a_q;
      sq_r_nx = sq_r_q >> 1;
    end
  end

  // shared datapath helpers
  logic signed [23:0] mx;
  logic signed [23:0] dnew;
  logic [22:0]        ad;
  logic [15:0]        ag;
  logic [31:0]        s_val;
  logic [63:0]        p2;
  logic [34:0]        q_y;
  logic signed [36:0] y_full;
  logic               in_acc;
  logic               out_take;
  logic               out_free;
  logic               elem_last;

  always_comb begin
    mx        = 24'($signed({1'b0, m_q})) * 24'(rd_sample);
    dnew      = mx - sum_q;
    ad        = dv_q[23] ? 23'(-dv_q) : dv_q[22:0];
    ag        = g_q[15] ? 16'(-g_q) : 16'(g_q);
    s_val     = div_num_nx[31:0] + 32'(eps_q);
    p2        = 64'(p1_q) * 64'(ag) + (64'(m_q) << 27);
    q_y       = div_num_nx[34:0];
    in_acc    = in_valid_i && !in_stall_o;
    out_take  = out_valid_q && !out_stall_i;
    out_free  = !out_valid_q || !out_stall_i;
    elem_last = (idx_q == m_q - 7'd1);
    if (dv_q[23] != g_q[15]) begin
      y_full = -$signed({2'b00, q_y});
    end else begin
      y_full = $signed({2'b00, q_y});
    end
    if (off_en_q) begin
      y_full = y_full + 37'(ofs_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lnv_pkg::ST_LOAD: begin
        if (in_acc && (cnt_q + 7'd1 >= eff_len)) begin
          state_d = lnv_pkg::ST_CUBE1;
        end
      end
      lnv_pkg::ST_CUBE1:  state_d = lnv_pkg::ST_CUBE2;
      lnv_pkg::ST_CUBE2:  state_d = lnv_pkg::ST_P1_RD;
      lnv_pkg::ST_P1_RD:  state_d = lnv_pkg::ST_P1_D;
      lnv_pkg::ST_P1_D:   state_d = lnv_pkg::ST_P1_SQ;
      lnv_pkg::ST_P1_SQ:  state_d = lnv_pkg::ST_P1_ACC;
      lnv_pkg::ST_P1_ACC: begin
        state_d = elem_last ? lnv_pkg::ST_DIV_VAR : lnv_pkg::ST_P1_RD;
      end
      lnv_pkg::ST_DIV_VAR: begin
        if (div_last) state_d = lnv_pkg::ST_DIV_INV;
      end
      lnv_pkg::ST_DIV_INV: begin
        if (div_last) state_d = lnv_pkg::ST_SQRT;
      end
      lnv_pkg::ST_SQRT: begin
        if (sq_cnt_q == '0) state_d = lnv_pkg::ST_P2_RD;
      end
      lnv_pkg::ST_P2_RD:   state_d = lnv_pkg::ST_P2_D;
      lnv_pkg::ST_P2_D:    state_d = lnv_pkg::ST_P2_MUL1;
      lnv_pkg::ST_P2_MUL1: state_d = lnv_pkg::ST_P2_MUL2;
      lnv_pkg::ST_P2_MUL2: state_d = lnv_pkg::ST_DIV_Y;
      lnv_pkg::ST_DIV_Y: begin
        if (div_last) state_d = lnv_pkg::ST_P2_OUT;
      end
      lnv_pkg::ST_P2_OUT: begin
        if (out_free) begin
          state_d = elem_last ? lnv_pkg::ST_LOAD : lnv_pkg::ST_P2_RD;
        end
      end
      default: state_d = lnv_pkg::ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    m_d         = m_q;
    idx_d       = idx_q;
    mm_d        = mm_q;
    m3_d        = m3_q;
    dv_d        = dv_q;
    sq_d        = sq_q;
    ssq_d       = ssq_q;
    g_d         = g_q;
    ofs_d       = ofs_q;
    p1_d        = p1_q;
    inv_d       = inv_q;
    y_d         = y_q;
    div_num_d   = div_num_q;
    div_rem_d   = div_rem_q;
    div_den_d   = div_den_q;
    div_cnt_d   = div_cnt_q;
    sq_a_d      = sq_a_q;
    sq_r_d      = sq_r_q;
    sq_cnt_d    = sq_cnt_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    out_d       = out_q;
    in_stall_o  = (state_q != lnv_pkg::ST_LOAD);

    case (state_q)
      lnv_pkg::ST_LOAD: begin
        if (in_acc) begin
          cnt_d = cnt_q + 7'd1;
          sum_d = sum_q + 24'(in_data_i.sample);
          m_d   = cnt_q + 7'd1;
        end
      end
      lnv_pkg::ST_CUBE1: begin
        mm_d  = 14'(m_q) * 14'(m_q);
        idx_d = '0;
        ssq_d = '0;
      end
      lnv_pkg::ST_CUBE2: m3_d = 19'(mm_q) * 19'(m_q);
      lnv_pkg::ST_P1_D:  dv_d = dnew;
      lnv_pkg::ST_P1_SQ: sq_d = 46'(ad) * 46'(ad);
      lnv_pkg::ST_P1_ACC: begin
        ssq_d = ssq_q + 52'(sq_q);
        if (elem_last) begin
          div_num_d = 64'(ssq_q + 52'(sq_q));
          div_den_d = 32'(m3_q);
          div_rem_d = '0;
          div_cnt_d = '0;
        end else begin
          idx_d = idx_q + 7'd1;
        end
      end
      lnv_pkg::ST_DIV_VAR: begin
        div_num_d = div_num_nx;
        div_rem_d = div_rem_nx;
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_last) begin
          // zero stabilized variance is taken as one
          div_num_d = 64'd1 << 48;
          div_den_d = (s_val == '0) ? 32'd1 : s_val;
          div_rem_d = '0;
          div_cnt_d = '0;
        end
      end
      lnv_pkg::ST_DIV_INV: begin
        div_num_d = div_num_nx;
        div_rem_d = div_rem_nx;
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_last) begin
          sq_a_d   = div_num_nx[48:0];
          sq_r_d   = '0;
          sq_cnt_d = 5'd24;
        end
      end
      lnv_pkg::ST_SQRT: begin
        sq_a_d   = sq_a_nx;
        sq_r_d   = sq_r_nx;
        sq_cnt_d = sq_cnt_q - 5'd1;
        if (sq_cnt_q == '0) begin
          inv_d = sq_r_nx[24:0];
          idx_d = '0;
        end
      end
      lnv_pkg::ST_P2_D: begin
        dv_d  = dnew;
        g_d   = rd_gain;
        ofs_d = rd_offset;
      end
      lnv_pkg::ST_P2_MUL1: p1_d = 48'(ad) * 48'(inv_q);
      lnv_pkg::ST_P2_MUL2: begin
        // round half away: add m * 2^27, drop 28 bits, divide by m
        div_num_d = 64'(p2[63:28]);
        div_den_d = 32'(m_q);
        div_rem_d = '0;
        div_cnt_d = '0;
      end
      lnv_pkg::ST_DIV_Y: begin
        div_num_d = div_num_nx;
        div_rem_d = div_rem_nx;
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_last) begin
          if (y_full > 37'sd32767) begin
            y_d = 16'sh7fff;
          end else if (y_full < -37'sd32768) begin
            y_d = -16'sh8000;
          end else begin
            y_d = y_full[15:0];
          end
        end
      end
      lnv_pkg::ST_P2_OUT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.norm_value     = y_q;
          out_d.last_of_vector = elem_last;
          if (elem_last) begin
            cnt_d = '0;
            sum_d = '0;
          end else begin
            idx_d = idx_q + 7'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lnv_pkg::ST_LOAD;
      cnt_q       <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      div_cnt_q   <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      div_cnt_q   <= div_cnt_d;
      sq_cnt_q    <= sq_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    mm_q      <= mm_d;
    m3_q      <= m3_d;
    dv_q      <= dv_d;
    sq_q      <= sq_d;
    ssq_q     <= ssq_d;
    g_q       <= g_d;
    ofs_q     <= ofs_d;
    p1_q      <= p1_d;
    inv_q     <= inv_d;
    y_q       <= y_d;
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    sq_a_q    <= sq_a_d;
    sq_r_q    <= sq_r_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/lnv_checker.sv =====
module lnv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lnv_pkg::out_beat_t out_data_o
);

  // a stalled result beat stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed under stall");

  // a new result is only produced while the input side is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while loading");

  // a loaded beat never produces a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result right after a load beat");

endmodule

bind layer_norm_vector_unit lnv_checker u_lnv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
